[src/lpqs_pkg.sv]
// Shared types and constants of the LED panel quarter-scan driver.
package lpqs_pkg;

	// Panel geometry that does not vary
	localparam int PANEL_HEIGHT = 16;

	// Operation codes of a command word
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FLUSH = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Register indexes on the configuration port
	localparam logic REG_ON_TIME   = 1'b0;
	localparam logic REG_DEAD_TIME = 1'b1;

	// Register reset values
	localparam logic [15:0] ON_TIME_RESET   = 16'd100;
	localparam logic [7:0]  DEAD_TIME_RESET = 8'd5;

	// Command word
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic       pixel_on;
	} cmd_t;

	// Pin-level word produced for each tick
	typedef struct packed {
		logic [1:0] row_select;
		logic       data_line;
		logic       shift_clock;
		logic       latch_strobe;
		logic       output_disable;
	} pins_t;

	// Bit request from the scan sequencer to the image stores
	typedef struct packed {
		logic        copy;
		logic [1:0]  row;
		logic [15:0] count;
	} scan_req_t;

endpackage

[src/lpqs_store.sv]
// Drawing, pending and shown image stores with the shift-bit lookup.
module lpqs_store #(
	parameter int PANEL_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  write_en,
	input  logic                  flush_en,
	input  logic [7:0]            pixel_x,
	input  logic [7:0]            pixel_y,
	input  logic                  pixel_on,
	input  lpqs_pkg::scan_req_t   req,
	output logic                  shown_bit
);

	localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
	localparam int ROW_BITS  = ROW_BYTES * 8;
	localparam int XW        = $clog2(ROW_BITS);

	logic [ROW_BITS-1:0] draw_q    [lpqs_pkg::PANEL_HEIGHT];
	logic [ROW_BITS-1:0] pending_q [lpqs_pkg::PANEL_HEIGHT];
	logic [ROW_BITS-1:0] shown_q   [lpqs_pkg::PANEL_HEIGHT];

	logic                in_panel;
	logic [3:0]          rd_y;
	logic [15:0]         rd_x;
	logic [ROW_BITS-1:0] rd_row;

	// Drop writes that fall outside the panel
	assign in_panel = ({1'b0, pixel_x} < 9'(PANEL_WIDTH)) &&
		({1'b0, pixel_y} < 9'(lpqs_pkg::PANEL_HEIGHT));

	// Update the stores: pixel writes, flush into pending, frame-start copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < lpqs_pkg::PANEL_HEIGHT; r++) begin
				draw_q[r]    <= '0;
				pending_q[r] <= '0;
				shown_q[r]   <= '0;
			end
		end else begin
			if (write_en && in_panel) begin
				draw_q[pixel_y[3:0]][pixel_x[XW-1:0]] <= pixel_on;
			end
			if (flush_en) begin
				pending_q <= draw_q;
			end
			if (req.copy) begin
				shown_q <= pending_q;
			end
		end
	end

	// Map the shift position to a pixel: four 8-bit groups per 32 bits,
	// bottom quarter first
	assign rd_y = {~req.count[5:4], req.row};
	assign rd_x = {3'b000, req.count[15:6], 3'b000} | {13'd0, req.count[3:1]};

	// Read the image that is shown on this tick
	assign rd_row    = req.copy ? pending_q[rd_y] : shown_q[rd_y];
	assign shown_bit = rd_row[rd_x[XW-1:0]];

endmodule

[src/lpqs_scan.sv]
// Scan-phase sequencer producing the pin levels for each tick.
module lpqs_scan #(
	parameter int PANEL_WIDTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_en,
	input  logic [15:0]         on_time,
	input  logic [7:0]          dead_time,
	input  logic                shown_bit,
	output lpqs_pkg::scan_req_t req,
	output lpqs_pkg::pins_t     pins
);

	localparam int          ROW_BYTES = (PANEL_WIDTH + 7) / 8;
	localparam logic [15:0] SHIFT_LEN = 16'(ROW_BYTES * 64);

	typedef enum logic [1:0] {
		PH_SHIFT,
		PH_LATCH,
		PH_DEAD,
		PH_ON
	} phase_t;

	phase_t      phase_q;
	logic [1:0]  row_q;
	logic [15:0] count_q;
	logic [1:0]  row_lines_q;

	phase_t      eff_ph;
	logic [1:0]  eff_row;
	logic [15:0] eff_cnt;

	function automatic logic [15:0] phase_len(phase_t ph, logic [15:0] on_t,
			logic [7:0] dead_t);
		logic [15:0] len;
		case (ph)
			PH_SHIFT: len = SHIFT_LEN;
			PH_LATCH: len = 16'd1;
			PH_DEAD:  len = {8'd0, dead_t};
			PH_ON:    len = on_t;
			default:  len = on_t;
		endcase
		return len;
	endfunction

	// Settle the phase: close finished phases and skip empty ones
	always_comb begin
		eff_ph  = phase_q;
		eff_row = row_q;
		eff_cnt = count_q;
		for (int i = 0; i < 3; i++) begin
			if (eff_cnt >= phase_len(eff_ph, on_time, dead_time)) begin
				eff_cnt = '0;
				case (eff_ph)
					PH_SHIFT: eff_ph = PH_LATCH;
					PH_LATCH: eff_ph = PH_DEAD;
					PH_DEAD:  eff_ph = PH_ON;
					PH_ON: begin
						eff_ph  = PH_SHIFT;
						eff_row = eff_row + 2'd1;
					end
					default:  eff_ph = PH_SHIFT;
				endcase
			end
		end
	end

	// Ask for the shift bit; start of scan row 0 takes the pending image
	always_comb begin
		req.copy  = tick_en && (eff_ph == PH_SHIFT) && (eff_row == 2'd0) &&
			(eff_cnt == 16'd0);
		req.row   = eff_row;
		req.count = eff_cnt;
	end

	// Drive the pin levels of the settled phase
	always_comb begin
		pins.row_select     = row_lines_q;
		pins.data_line      = 1'b1;
		pins.shift_clock    = 1'b0;
		pins.latch_strobe   = 1'b0;
		pins.output_disable = 1'b1;
		case (eff_ph)
			PH_SHIFT: begin
				pins.data_line   = ~shown_bit;
				pins.shift_clock = eff_cnt[0];
			end
			PH_LATCH: begin
				pins.latch_strobe = 1'b1;
				pins.row_select   = eff_row;
			end
			PH_ON: begin
				pins.output_disable = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Advance the sequencer on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SHIFT;
			row_q       <= 2'd0;
			count_q     <= 16'd0;
			row_lines_q <= 2'd0;
		end else if (tick_en) begin
			phase_q <= eff_ph;
			row_q   <= eff_row;
			count_q <= eff_cnt + 16'd1;
			if (eff_ph == PH_LATCH) begin
				row_lines_q <= eff_row;
			end
		end
	end

	// The latch tick loads the row lines with its scan row
	a_latch_row: assert property (@(posedge clk) disable iff (!arst_n)
		tick_en && (eff_ph == PH_LATCH) |=> row_lines_q == $past(eff_row))
		else $error("row lines not loaded on latch tick");

	// A settled shift phase stays inside the shift length
	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tick_en && (eff_ph == PH_SHIFT) |-> eff_cnt < SHIFT_LEN)
		else $error("shift position beyond row length");

	// A settled on phase stays inside the on time
	a_on_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tick_en && (eff_ph == PH_ON) |-> eff_cnt < on_time)
		else $error("on phase beyond on time");

endmodule

[src/led_panel_quarter_scan_driver_unit.sv]
// Top level of the LED panel quarter-scan driver: channels, registers, staging.
//
// Commands arrive on cmd (cmd_valid/cmd_ready): pixel write, flush of the
// drawing image into the pending image, or one tick. Only a tick yields a
// word on pins (pin_valid/pin_ready): row select, serial data, shift clock,
// latch strobe and output disable for that step of the scan.
// A command accepted at one edge is worked from the input register; a
// tick's pin word is loaded into the pin register, which drives pin_valid.
// One command is taken per cycle, sustained, while no tick waits on a
// stalled pin word; the whole step is one pass of settle logic and a store
// bit select between the input register and the pin register.
// on_time (address 0) and dead_time (address 4) are written over the APB
// port; pready is always high.
// Reset clears all three image stores and the scan state, and sets on_time
// to 100 and dead_time to 5.
// When the receiver stalls, the pin word holds; a tick in the input
// register then waits and cmd_ready stays low until the pin word is taken.
// A write or flush in the input register passes regardless of the stall.
module led_panel_quarter_scan_driver_unit #(
	parameter int PANEL_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  lpqs_pkg::cmd_t    cmd,
	output logic              pin_valid,
	input  logic              pin_ready,
	output lpqs_pkg::pins_t   pins,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic                cmd_valid_s1;
	lpqs_pkg::cmd_t      cmd_s1;
	logic                pin_valid_s2;
	lpqs_pkg::pins_t     pins_s2;
	logic [15:0]         on_time_q;
	logic [7:0]          dead_time_q;

	logic                s1_is_tick;
	logic                out_free;
	logic                s1_fire;
	logic                tick_fire;
	logic                shown_bit;
	lpqs_pkg::scan_req_t req;
	lpqs_pkg::pins_t     pins_next;

	// Register file: write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q   <= lpqs_pkg::ON_TIME_RESET;
			dead_time_q <= lpqs_pkg::DEAD_TIME_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				lpqs_pkg::REG_ON_TIME:   on_time_q   <= pwdata[15:0];
				lpqs_pkg::REG_DEAD_TIME: dead_time_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (paddr[2])
			lpqs_pkg::REG_ON_TIME:   prdata = {16'd0, on_time_q};
			lpqs_pkg::REG_DEAD_TIME: prdata = {24'd0, dead_time_q};
			default:                 prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;

	// Let a word leave the input register unless it is a tick facing a full
	// pin register
	assign s1_is_tick = cmd_s1.operation == lpqs_pkg::OP_TICK;
	assign out_free   = !pin_valid_s2 || pin_ready;
	assign s1_fire    = cmd_valid_s1 && (!s1_is_tick || out_free);
	assign tick_fire  = s1_fire && s1_is_tick;
	assign cmd_ready  = !cmd_valid_s1 || s1_fire;

	// Hold the accepted command word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	lpqs_store #(
		.PANEL_WIDTH(PANEL_WIDTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.write_en  (s1_fire && (cmd_s1.operation == lpqs_pkg::OP_WRITE)),
		.flush_en  (s1_fire && (cmd_s1.operation == lpqs_pkg::OP_FLUSH)),
		.pixel_x   (cmd_s1.pixel_x),
		.pixel_y   (cmd_s1.pixel_y),
		.pixel_on  (cmd_s1.pixel_on),
		.req       (req),
		.shown_bit (shown_bit)
	);

	lpqs_scan #(
		.PANEL_WIDTH(PANEL_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_en   (tick_fire),
		.on_time   (on_time_q),
		.dead_time (dead_time_q),
		.shown_bit (shown_bit),
		.req       (req),
		.pins      (pins_next)
	);

	// Load the pin word on a tick, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_valid_s2 <= 1'b0;
		end else if (tick_fire) begin
			pin_valid_s2 <= 1'b1;
		end else if (pin_ready) begin
			pin_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			pins_s2 <= pins_next;
		end
	end

	assign pin_valid = pin_valid_s2;
	assign pins      = pins_s2;

	// A new pin word comes only from a tick
	a_word_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pin_valid_s2) |-> $past(tick_fire))
		else $error("pin word without a tick");

	// Every tick leaves a pin word behind
	a_tick_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire |=> pin_valid_s2)
		else $error("tick lost");

endmodule
